// ===== design/cfs_pkg.sv =====
`timescale 1ns / 1ps
package cfs_pkg;

  // one tick of input
  typedef struct packed {
    logic        power_good;
    logic [15:0] volt_avg;
    logic [15:0] curr_avg;
    logic [15:0] volt_target;
    logic [15:0] curr_target;
    logic        output_request;
    logic [1:0]  mode_now;
  } cfs_in_t;

  // one result
  typedef struct packed {
    logic       relay_drive;
    logic [1:0] mode_next;
    logic       fault_power_low;
    logic       fault_overvoltage;
    logic       fault_overcurrent;
    logic       ready_res;
  } cfs_out_t;

  // configuration register indexes
  typedef enum logic [2:0] {
    CFG_OV_VOLTAGE_MARGIN = 3'd0,
    CFG_OV_CURRENT_MARGIN = 3'd1,
    CFG_OV_TICKS          = 3'd2,
    CFG_OC_LIMIT          = 3'd3,
    CFG_OC_TICKS          = 3'd4,
    CFG_STARTUP_TICKS     = 3'd5
  } cfs_cfg_idx_e;

  typedef struct packed {
    logic [14:0] ov_voltage_margin;
    logic [14:0] ov_current_margin;
    logic [6:0]  ov_ticks;
    logic [15:0] oc_limit;
    logic [6:0]  oc_ticks;
    logic [1:0]  startup_ticks;
  } cfs_cfg_t;

  // fault flags after a tick
  typedef struct packed {
    logic power_low;
    logic overvoltage;
    logic overcurrent;
  } cfs_fault_t;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  localparam logic [14:0] OV_VOLTAGE_MARGIN_RST = 15'd170;
  localparam logic [14:0] OV_CURRENT_MARGIN_RST = 15'd50;
  localparam logic [6:0]  OV_TICKS_RST          = 7'd25;
  localparam logic [15:0] OC_LIMIT_RST          = 16'd3072;
  localparam logic [6:0]  OC_TICKS_RST          = 7'd15;
  localparam logic [1:0]  STARTUP_TICKS_RST     = 2'd3;

  localparam logic [5:0] PWR_STEP_UP = 6'd5;
  localparam logic [5:0] PWR_TOP     = 6'd50;
  localparam logic [6:0] CNT_TOP     = 7'd127;

  localparam logic [1:0] MODE_OFF = 2'd0;
  localparam logic [1:0] MODE_CC  = 2'd1;

endpackage

// ===== design/charger_fault_supervisor.sv =====
`timescale 1ns / 1ps
// path: an accepted transfer goes through the input register, then the result register
// throughput: one transfer per cycle while out_stall_i stays low; the two registers are
//   decoupled so a new tick is taken while a finished result waits downstream
// reset: rst_ni async active low; filters, fault flags, start-up state and
//   configuration registers return to their defaults, both pipeline stages empty
module charger_fault_supervisor (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // input tick channel
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  cfs_pkg::cfs_in_t              in_data_i,
  // result channel
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output cfs_pkg::cfs_out_t             out_data_o,
  // configuration write port
  input  logic                          cfg_we_i,
  input  logic [cfs_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [cfs_pkg::CfgDataW-1:0]  cfg_wdata_i
);
  import cfs_pkg::*;

  // input register stage
  logic     s1_valid_q, s1_valid_d;
  cfs_in_t  s1_data_q;
  // result register stage
  logic     out_valid_q, out_valid_d;
  cfs_out_t out_data_q;

  logic       in_xfer;
  logic       adv;       // input stage moves into result register, state updates
  cfs_cfg_t   cfg;
  cfs_fault_t fault_next;
  cfs_out_t   res;

  // result register can take a new value when empty or being drained
  assign adv        = s1_valid_q && (!out_valid_q || !out_stall_i);
  // input stage only holds off when full and unable to move on
  assign in_stall_o = s1_valid_q && !adv;
  assign in_xfer    = in_valid_i && !in_stall_o;

  always_comb begin
    s1_valid_d  = s1_valid_q;
    out_valid_d = out_valid_q;
    if (adv)                            s1_valid_d = 1'b0;
    if (in_xfer)                        s1_valid_d = 1'b1;
    if (out_valid_q && !out_stall_i)    out_valid_d = 1'b0;
    if (adv)                            out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_xfer) s1_data_q  <= in_data_i;
    if (adv)     out_data_q <= res;
  end

  cfs_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // power, overvoltage and overcurrent filters with the fault flags
  cfs_fault_filter u_filter (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .item_i  (s1_data_q),
    .cfg_i   (cfg),
    .fault_o (fault_next)
  );

  // relay start-up sequence and mode control
  cfs_startup_seq u_seq (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .adv_i           (adv),
    .item_i          (s1_data_q),
    .fault_i         (fault_next),
    .startup_ticks_i (cfg.startup_ticks),
    .res_o           (res)
  );

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // relay is never driven while any failure is reported
  a_relay_no_fault: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.relay_drive) |->
      !(out_data_o.fault_power_low || out_data_o.fault_overvoltage ||
        out_data_o.fault_overcurrent))
    else $error("relay driven during failure");

  // ready implies relay on
  a_ready_relay: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.ready_res) |-> out_data_o.relay_drive)
    else $error("ready without relay");

  // an empty input stage never holds off the sender
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_valid_q)
    else $error("input stalled while input stage empty");

endmodule

// ===== design/cfs_cfg_regs.sv =====
`timescale 1ns / 1ps
module cfs_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [cfs_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [cfs_pkg::CfgDataW-1:0]  cfg_wdata_i,
  output cfs_pkg::cfs_cfg_t             cfg_o
);
  import cfs_pkg::*;

  cfs_cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfs_cfg_idx_e'(cfg_idx_i))
        CFG_OV_VOLTAGE_MARGIN: cfg_d.ov_voltage_margin = cfg_wdata_i[14:0];
        CFG_OV_CURRENT_MARGIN: cfg_d.ov_current_margin = cfg_wdata_i[14:0];
        CFG_OV_TICKS:          cfg_d.ov_ticks          = cfg_wdata_i[6:0];
        CFG_OC_LIMIT:          cfg_d.oc_limit          = cfg_wdata_i[15:0];
        CFG_OC_TICKS:          cfg_d.oc_ticks          = cfg_wdata_i[6:0];
        CFG_STARTUP_TICKS:     cfg_d.startup_ticks     = cfg_wdata_i[1:0];
        default:               cfg_d = cfg_q; // unmapped index, ignored
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.ov_voltage_margin <= OV_VOLTAGE_MARGIN_RST;
      cfg_q.ov_current_margin <= OV_CURRENT_MARGIN_RST;
      cfg_q.ov_ticks          <= OV_TICKS_RST;
      cfg_q.oc_limit          <= OC_LIMIT_RST;
      cfg_q.oc_ticks          <= OC_TICKS_RST;
      cfg_q.startup_ticks     <= STARTUP_TICKS_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== design/cfs_fault_filter.sv =====
`timescale 1ns / 1ps
module cfs_fault_filter (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                adv_i,
  input  cfs_pkg::cfs_in_t    item_i,
  input  cfs_pkg::cfs_cfg_t   cfg_i,
  output cfs_pkg::cfs_fault_t fault_o
);
  import cfs_pkg::*;

  logic [5:0] pwr_cnt_q, pwr_cnt_d;
  logic [6:0] ov_cnt_q, ov_cnt_d;
  logic [6:0] oc_cnt_q, oc_cnt_d;
  cfs_fault_t flt_q, flt_d;

  logic [5:0]        pwr_sum;
  logic signed [17:0] volt_ex, curr_ex;
  logic              ov_hit, oc_hit;
  logic [6:0]        ov_up, oc_up;

  // exact differences, no 16-bit wrap
  assign volt_ex = $signed({2'b00, item_i.volt_avg}) - $signed({2'b00, item_i.volt_target});
  assign curr_ex = $signed({2'b00, item_i.curr_avg}) - $signed({2'b00, item_i.curr_target});
  assign ov_hit  = (volt_ex > $signed({3'b000, cfg_i.ov_voltage_margin})) &&
                   (curr_ex > $signed({3'b000, cfg_i.ov_current_margin}));
  assign oc_hit  = item_i.curr_avg > cfg_i.oc_limit;

  assign ov_up   = (ov_cnt_q == CNT_TOP) ? CNT_TOP : ov_cnt_q + 7'd1;
  assign oc_up   = (oc_cnt_q == CNT_TOP) ? CNT_TOP : oc_cnt_q + 7'd1;
  assign pwr_sum = pwr_cnt_q + PWR_STEP_UP;

  always_comb begin
    pwr_cnt_d = pwr_cnt_q;
    ov_cnt_d  = 7'd0;
    oc_cnt_d  = 7'd0;
    flt_d     = flt_q;

    // asymmetric power filter, sets and clears its own flag
    if (item_i.power_good) begin
      if (pwr_sum >= PWR_TOP) begin
        pwr_cnt_d       = PWR_TOP;
        flt_d.power_low = 1'b0;
      end else begin
        pwr_cnt_d = pwr_sum;
      end
    end else if (pwr_cnt_q == 6'd0) begin
      flt_d.power_low = 1'b1;
    end else begin
      pwr_cnt_d = pwr_cnt_q - 6'd1;
    end

    if (ov_hit) begin
      ov_cnt_d = ov_up;
      if (ov_up >= cfg_i.ov_ticks) flt_d.overvoltage = 1'b1;
    end
    if (oc_hit) begin
      oc_cnt_d = oc_up;
      if (oc_up >= cfg_i.oc_ticks) flt_d.overcurrent = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pwr_cnt_q <= 6'd0;
      ov_cnt_q  <= 7'd0;
      oc_cnt_q  <= 7'd0;
      flt_q     <= '0;
    end else if (adv_i) begin
      pwr_cnt_q <= pwr_cnt_d;
      ov_cnt_q  <= ov_cnt_d;
      oc_cnt_q  <= oc_cnt_d;
      flt_q     <= flt_d;
    end
  end

  assign fault_o = flt_d;

  // latched faults never clear outside reset
  a_ov_latch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    flt_q.overvoltage |=> flt_q.overvoltage)
    else $error("overvoltage flag cleared");

  a_oc_latch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    flt_q.overcurrent |=> flt_q.overcurrent)
    else $error("overcurrent flag cleared");

  // power low only clears once the filter reached its top
  a_pwr_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(flt_q.power_low) |-> (pwr_cnt_q == PWR_TOP))
    else $error("power low cleared below filter top");

endmodule

// ===== design/cfs_startup_seq.sv =====
`timescale 1ns / 1ps
module cfs_startup_seq (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                adv_i,
  input  cfs_pkg::cfs_in_t    item_i,
  input  cfs_pkg::cfs_fault_t fault_i,
  input  logic [1:0]          startup_ticks_i,
  output cfs_pkg::cfs_out_t   res_o
);
  import cfs_pkg::*;

  logic       ready_q, ready_d;
  logic [1:0] cnt_q, cnt_d;
  logic [1:0] cnt_inc;
  logic       any_fault;
  logic       relay;
  logic [1:0] mode;

  assign any_fault = fault_i.power_low | fault_i.overvoltage | fault_i.overcurrent;
  assign cnt_inc   = cnt_q + 2'd1;

  always_comb begin
    ready_d = ready_q;
    cnt_d   = cnt_q;
    relay   = 1'b1;
    mode    = item_i.mode_now;
    if (any_fault) begin
      relay   = 1'b0;
      mode    = MODE_OFF;
      ready_d = 1'b0;
      cnt_d   = 2'd0;
    end else if (ready_q) begin
      if (!item_i.output_request)          mode = MODE_OFF;
      else if (item_i.mode_now == MODE_OFF) mode = MODE_CC;
    end else begin
      // zero start-up ticks behaves like one
      if (cnt_inc >= startup_ticks_i) begin
        ready_d = 1'b1;
        cnt_d   = 2'd0;
      end else begin
        cnt_d = cnt_inc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ready_q <= 1'b0;
      cnt_q   <= 2'd0;
    end else if (adv_i) begin
      ready_q <= ready_d;
      cnt_q   <= cnt_d;
    end
  end

  always_comb begin
    res_o.relay_drive       = relay;
    res_o.mode_next         = mode;
    res_o.fault_power_low   = fault_i.power_low;
    res_o.fault_overvoltage = fault_i.overvoltage;
    res_o.fault_overcurrent = fault_i.overcurrent;
    res_o.ready_res         = ready_d;
  end

endmodule
